@@ design/bcpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve point evaluator package
// Shared constants, configuration register codes and datapath chunk size.
// ----------------------------------------------------------------------------

package bcpe_pkg;

  // Default geometry: signed Q8.8 coordinates, Q1.16 curve parameter
  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  // Wide multiplies by t are split into slices of this many bits
  localparam int CHUNK_W = 24;

  // Configuration register index
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE_MODE     = 3'd0,
    CFG_START_POINT    = 3'd1,
    CFG_FIRST_CONTROL  = 3'd2,
    CFG_SECOND_CONTROL = 3'd3,
    CFG_END_POINT      = 3'd4
  } bcpe_cfg_idx_t;

endpackage

@@ design/bcpe_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator interpolation level
// One de Casteljau level for all three axes: out[k] = a*2^F + t*(b - a),
// with a = in[k], b = in[k+1]. Exact, four register stages.
// ----------------------------------------------------------------------------

module bcpe_level
  import bcpe_pkg::*;
#(
  parameter int IN_W   = 16,
  parameter int T_FRAC = 16,
  parameter int NUM    = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [T_FRAC:0]                 in_t,
  input  logic signed [IN_W-1:0]          in_pts  [3][NUM+1],
  output logic                            out_vld,
  output logic [T_FRAC:0]                 out_t,
  output logic signed [IN_W+T_FRAC-1:0]   out_pts [3][NUM]
);

  localparam int T_W   = T_FRAC + 1;
  localparam int OUT_W = IN_W + T_FRAC;
  localparam int DW    = IN_W + 1;
  localparam int NCH   = (DW + CHUNK_W - 1) / CHUNK_W;
  localparam int TOPW  = DW - (NCH - 1) * CHUNK_W;
  localparam int PPW   = CHUNK_W + T_W + 1;
  localparam int PW    = DW + T_W + 1;

  // valid and parameter travel with the data
  logic           s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [T_W-1:0] s1_t_r, s2_t_r, s3_t_r, s4_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r <= in_t;
      s2_t_r <= s1_t_r;
      s3_t_r <= s2_t_r;
      s4_t_r <= s3_t_r;
    end
  end

  assign out_vld = s4_vld_r;
  assign out_t   = s4_t_r;

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    for (genvar k = 0; k < NUM; k++) begin : g_lerp
      logic signed [DW-1:0]    diff_r;
      logic signed [IN_W-1:0]  base1_r, base2_r, base3_r;
      logic signed [PPW-1:0]   pp_nxt [NCH];
      logic signed [PPW-1:0]   pp_r   [NCH];
      logic signed [PW-1:0]    prod_nxt;
      logic signed [PW-1:0]    prod_r;
      logic signed [OUT_W-1:0] res_r;

      // stage 1: difference of neighbors
      always_ff @(posedge clk) begin
        if (en) begin
          diff_r  <= {in_pts[ax][k+1][IN_W-1], in_pts[ax][k+1]}
                   - {in_pts[ax][k][IN_W-1], in_pts[ax][k]};
          base1_r <= in_pts[ax][k];
        end
      end

      // stage 2: partial products, one slice of the difference each
      for (genvar j = 0; j < NCH; j++) begin : g_pp
        if (j == NCH - 1) begin : g_top
          logic signed [TOPW-1:0]  top;
          logic signed [TOPW+T_W:0] prod_top;
          assign top      = diff_r[DW-1 -: TOPW];
          assign prod_top = top * $signed({1'b0, s1_t_r});
          assign pp_nxt[j] = PPW'(prod_top);
        end else begin : g_low
          logic [CHUNK_W+T_W-1:0] prod_lo;
          assign prod_lo   = diff_r[j*CHUNK_W +: CHUNK_W] * s1_t_r;
          assign pp_nxt[j] = $signed({1'b0, prod_lo});
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pp_r    <= pp_nxt;
          base2_r <= base1_r;
        end
      end

      // stage 3: reassemble the full product t*(b - a)
      always_comb begin
        prod_nxt = '0;
        for (int j = 0; j < NCH; j++) begin
          prod_nxt = prod_nxt + (PW'(pp_r[j]) <<< (j * CHUNK_W));
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          prod_r  <= prod_nxt;
          base3_r <= base2_r;
        end
      end

      // stage 4: add the scaled base; result stays in the hull range
      always_ff @(posedge clk) begin
        if (en) begin
          res_r <= OUT_W'((PW'(base3_r) <<< T_FRAC) + prod_r);
        end
      end

      assign out_pts[ax][k] = res_r;
    end
  end

endmodule

@@ design/bezier_curve_point_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Quadratic or cubic 3-D Bezier point B(t) by exact de Casteljau levels,
// rounded to nearest once at the end.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid / in_stall   | in_param_t (Q1.F unsigned)
//   out     | output    | out_valid / out_stall | out_point_x/y/z (signed)
//   cfg     | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall is low; each beat passes the
// input register, three interpolation levels of four stages, output register.
// Reset clears valid state and loads curve_mode = cubic, all points zero.
// The output register has a one-beat skid; while the skid is full the whole
// pipeline holds and in_stall is high.
// ----------------------------------------------------------------------------

module bezier_curve_point_evaluator
  import bcpe_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [T_FRAC_BITS:0]          in_param_t,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic signed [COORD_WIDTH-1:0] out_point_z,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [3*COORD_WIDTH-1:0]      cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int TF   = T_FRAC_BITS;
  localparam int T_W  = TF + 1;
  localparam int PT_W = 3 * CW;
  localparam int W1   = CW + TF;
  localparam int W2   = CW + 2 * TF;
  localparam int W3   = CW + 3 * TF;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << TF;
  localparam logic [W3-1:0]  HALF  = W3'(1) << (3 * TF - 1);

  // configuration registers
  logic            curve_mode_r;
  logic [PT_W-1:0] start_point_r, first_control_r, second_control_r, end_point_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r     <= 1'b1;
      start_point_r    <= '0;
      first_control_r  <= '0;
      second_control_r <= '0;
      end_point_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CURVE_MODE:     curve_mode_r     <= cfg_wdata[0];
        CFG_START_POINT:    start_point_r    <= cfg_wdata;
        CFG_FIRST_CONTROL:  first_control_r  <= cfg_wdata;
        CFG_SECOND_CONTROL: second_control_r <= cfg_wdata;
        CFG_END_POINT:      end_point_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: held only while the skid holds a beat
  logic stage_en;
  logic skid_valid_r, out_valid_r;

  assign stage_en = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // input register, t clamped to one
  logic           in_vld_r;
  logic [T_W-1:0] t_r, t_sat;

  assign t_sat = (in_param_t > T_ONE) ? T_ONE : in_param_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (stage_en) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      t_r <= t_sat;
    end
  end

  // control points; quadratic mode runs as P0, P1, P3, P3
  logic signed [CW-1:0] pts0 [3][4];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      pts0[ax][0] = start_point_r[ax*CW +: CW];
      pts0[ax][1] = first_control_r[ax*CW +: CW];
      pts0[ax][2] = curve_mode_r ? second_control_r[ax*CW +: CW]
                                 : end_point_r[ax*CW +: CW];
      pts0[ax][3] = end_point_r[ax*CW +: CW];
    end
  end

  // three interpolation levels
  logic                 l1_vld, l2_vld, l3_vld;
  logic [T_W-1:0]       l1_t, l2_t, l3_t, l3_t_in;
  logic signed [W1-1:0] l1_pts [3][3];
  logic signed [W2-1:0] l2_pts [3][2];
  logic signed [W3-1:0] l3_pts [3][1];

  bcpe_level #(.IN_W(CW), .T_FRAC(TF), .NUM(3)) u_level1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (stage_en),
    .in_vld  (in_vld_r),
    .in_t    (t_r),
    .in_pts  (pts0),
    .out_vld (l1_vld),
    .out_t   (l1_t),
    .out_pts (l1_pts)
  );

  bcpe_level #(.IN_W(W1), .T_FRAC(TF), .NUM(2)) u_level2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (stage_en),
    .in_vld  (l1_vld),
    .in_t    (l1_t),
    .in_pts  (l1_pts),
    .out_vld (l2_vld),
    .out_t   (l2_t),
    .out_pts (l2_pts)
  );

  // quadratic: last level only scales by 2^F (t forced to zero)
  assign l3_t_in = curve_mode_r ? l2_t : '0;

  bcpe_level #(.IN_W(W2), .T_FRAC(TF), .NUM(1)) u_level3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (stage_en),
    .in_vld  (l2_vld),
    .in_t    (l3_t_in),
    .in_pts  (l2_pts),
    .out_vld (l3_vld),
    .out_t   (l3_t),
    .out_pts (l3_pts)
  );

  // round to nearest, ties up: add half, keep the top CW bits
  logic [W3-1:0]        rnd [3];
  logic signed [CW-1:0] res [3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      rnd[ax] = l3_pts[ax][0] + HALF;
      res[ax] = rnd[ax][W3-1 -: CW];
    end
  end

  // output register with one-beat skid
  logic                 pop, push;
  logic signed [CW-1:0] out_pt_r  [3];
  logic signed [CW-1:0] skid_pt_r [3];

  assign pop  = out_valid_r && !out_stall;
  assign push = stage_en && l3_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (pop) begin
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || pop) begin
        out_valid_r <= push;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (pop) begin
        out_pt_r <= skid_pt_r;
      end
    end else if (!out_valid_r || pop) begin
      out_pt_r <= res;
    end else if (push) begin
      skid_pt_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_pt_r[0];
  assign out_point_y = out_pt_r[1];
  assign out_point_z = out_pt_r[2];

`ifndef SYNTHESIS
  // skid only ever holds a beat behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");

  // skid fills only when the output was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without an output stall");

  // a finished beat from the last level always lands in the output buffer
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_en && l3_vld) |=> out_valid_r)
    else $error("finished beat lost at the output");

  // parameter leaving the last level never exceeds one
  a_l3_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    l3_vld |-> (l3_t <= T_ONE))
    else $error("last-level parameter above one");
`endif

endmodule
